FILE: rtl/core/box_frustum_cull_test_unit_defines.svh
// assertion macros shared by the box frustum cull test unit
// no dependencies; included by the files that carry assertions
`ifndef BOX_FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH
`define BOX_FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BFCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bfct_pkg.sv
// shared types and constants of the box frustum cull test unit
// no dependencies
package bfct_pkg;

  // fixed field formats
  localparam int COEF_W   = 14;  // plane a, b, c, signed Q1.12
  localparam int DIST_W   = 22;  // plane d, signed Q13.8
  localparam int CTR_W    = 24;  // box center, signed Q15.8
  localparam int HALF_W   = 23;  // box half extent, unsigned Q15.8
  localparam int CORN_W   = 25;  // corner coordinate, signed Q16.8
  localparam int PROD_W   = COEF_W + CORN_W;
  localparam int BIAS_W   = 32;
  localparam int FRAC_ALN = 12;  // aligns Q.8 terms with Q.20 products
  localparam int SUM_W    = 45;
  localparam int PLANE_W  = 64;
  localparam int IDX_W    = 3;
  localparam int NUM_PLANES = 6;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_NEAR   = 3'd0,
    REG_FAR    = 3'd1,
    REG_LEFT   = 3'd2,
    REG_RIGHT  = 3'd3,
    REG_TOP    = 3'd4,
    REG_BOTTOM = 3'd5,
    REG_BIAS   = 3'd6
  } bfct_reg_t;

  // box as its low and high corners
  typedef struct packed {
    logic signed [CORN_W-1:0] lo_x;
    logic signed [CORN_W-1:0] lo_y;
    logic signed [CORN_W-1:0] lo_z;
    logic signed [CORN_W-1:0] hi_x;
    logic signed [CORN_W-1:0] hi_y;
    logic signed [CORN_W-1:0] hi_z;
  } bfct_box_t;

endpackage

FILE: rtl/core/bfct_cell.sv
// one plane cell: holds a plane, tests the box's farthest corner against it
// depends on bfct_pkg and box_frustum_cull_test_unit_defines.svh
`include "box_frustum_cull_test_unit_defines.svh"

module bfct_cell #(
  parameter bfct_pkg::bfct_reg_t PLANE_IDX = bfct_pkg::REG_NEAR
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bfct_pkg::IDX_W-1:0]          cfg_index,
  input  logic [bfct_pkg::PLANE_W-1:0]        cfg_wdata,
  input  logic signed [bfct_pkg::BIAS_W-1:0]  bias,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  bfct_pkg::bfct_box_t                 up_box,
  input  logic                                up_inside,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output bfct_pkg::bfct_box_t                 dn_box,
  output logic                                dn_inside
);

  logic [bfct_pkg::PLANE_W-1:0] plane_r;

  logic signed [bfct_pkg::COEF_W-1:0] coef_a, coef_b, coef_c;
  logic signed [bfct_pkg::DIST_W-1:0] dist_d;
  logic signed [bfct_pkg::CORN_W-1:0] sel_x, sel_y, sel_z;
  logic signed [bfct_pkg::PROD_W-1:0] prod_a_nxt, prod_b_nxt, prod_c_nxt;
  logic signed [bfct_pkg::PROD_W-1:0] prod_a_r, prod_b_r, prod_c_r;
  logic signed [bfct_pkg::SUM_W-1:0]  dist_sum, bias_term;
  logic                               keep;

  logic                s1_v_r, s1_inside_r;
  bfct_pkg::bfct_box_t s1_box_r;
  logic                s2_v_r, s2_inside_r;
  bfct_pkg::bfct_box_t s2_box_r;
  logic                s1_en, s2_en;

  // plane register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_we && (cfg_index == PLANE_IDX)) begin
      plane_r <= cfg_wdata;
    end
  end

  // unpack coefficients
  assign coef_a = plane_r[13:0];
  assign coef_b = plane_r[27:14];
  assign coef_c = plane_r[41:28];
  assign dist_d = plane_r[63:42];

  // stage enables, a stage takes new data when empty or draining
  assign s2_en    = !s2_v_r || dn_ready;
  assign s1_en    = !s1_v_r || s2_en;
  assign up_ready = s1_en;

  // farthest corner along the plane normal, one product per axis
  always_comb begin
    sel_x = coef_a[bfct_pkg::COEF_W-1] ? up_box.lo_x : up_box.hi_x;
    sel_y = coef_b[bfct_pkg::COEF_W-1] ? up_box.lo_y : up_box.hi_y;
    sel_z = coef_c[bfct_pkg::COEF_W-1] ? up_box.lo_z : up_box.hi_z;
    prod_a_nxt = coef_a * sel_x;
    prod_b_nxt = coef_b * sel_y;
    prod_c_nxt = coef_c * sel_z;
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      prod_a_r    <= prod_a_nxt;
      prod_b_r    <= prod_b_nxt;
      prod_c_r    <= prod_c_nxt;
      s1_box_r    <= up_box;
      s1_inside_r <= up_inside;
    end
  end

  // distance sum and threshold compare, both at 20 fraction bits
  always_comb begin
    dist_sum = bfct_pkg::SUM_W'(prod_a_r) + bfct_pkg::SUM_W'(prod_b_r)
             + bfct_pkg::SUM_W'(prod_c_r)
             + bfct_pkg::SUM_W'($signed({dist_d, {bfct_pkg::FRAC_ALN{1'b0}}}));
    bias_term = bfct_pkg::SUM_W'($signed({bias, {bfct_pkg::FRAC_ALN{1'b0}}}));
    keep = (dist_sum >= bias_term);
  end

  // compare stage, drives the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_box_r    <= s1_box_r;
      s2_inside_r <= s1_inside_r && keep;
    end
  end

  assign dn_valid  = s2_v_r;
  assign dn_box    = s2_box_r;
  assign dn_inside = s2_inside_r;

  // checks
  `BFCT_ASSERT_NEXT(a_stall_holds, clk, rst_n, s2_v_r && !dn_ready, s2_v_r,
    "stalled request left the compare stage")
  `BFCT_ASSERT_NEXT(a_culled_stays, clk, rst_n, s2_en && s1_v_r && !s1_inside_r,
    !s2_inside_r, "culled box came back inside")
  `BFCT_ASSERT_NOW(a_empty_ready, clk, rst_n, !s1_v_r, up_ready,
    "empty product stage refused a request")

endmodule

FILE: rtl/core/box_frustum_cull_test_unit.sv
// box frustum cull test: from input accept to result valid a box passes one front
// stage forming the box corners, then two stages in each of six plane cells;
// throughput one box per cycle while out_ready is high, set by the cell chain pipeline.
// the last cell's compare stage is the output register.
// synchronous active-low reset clears all valid flags and every
// configuration register to zero.
// depends on bfct_pkg and bfct_cell
module box_frustum_cull_test_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bfct_pkg::IDX_W-1:0]          cfg_index,
  input  logic [bfct_pkg::PLANE_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bfct_pkg::CTR_W-1:0]   in_center_x,
  input  logic signed [bfct_pkg::CTR_W-1:0]   in_center_y,
  input  logic signed [bfct_pkg::CTR_W-1:0]   in_center_z,
  input  logic [bfct_pkg::HALF_W-1:0]         in_half_x,
  input  logic [bfct_pkg::HALF_W-1:0]         in_half_y,
  input  logic [bfct_pkg::HALF_W-1:0]         in_half_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_inside_res
);

  localparam int NP = bfct_pkg::NUM_PLANES;
  localparam int CW = bfct_pkg::CORN_W;

  logic signed [bfct_pkg::BIAS_W-1:0] bias_r;
  logic                f_v_r, f_en;
  bfct_pkg::bfct_box_t box_nxt, f_box_r;

  logic                chain_v   [0:NP];
  logic                chain_rdy [0:NP];
  logic                chain_ins [0:NP];
  bfct_pkg::bfct_box_t chain_box [0:NP];

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (cfg_we && (cfg_index == bfct_pkg::REG_BIAS)) begin
      bias_r <= cfg_wdata[bfct_pkg::BIAS_W-1:0];
    end
  end

  // box corners from center and half extents
  always_comb begin
    box_nxt.lo_x = CW'(in_center_x) - $signed(CW'(in_half_x));
    box_nxt.lo_y = CW'(in_center_y) - $signed(CW'(in_half_y));
    box_nxt.lo_z = CW'(in_center_z) - $signed(CW'(in_half_z));
    box_nxt.hi_x = CW'(in_center_x) + $signed(CW'(in_half_x));
    box_nxt.hi_y = CW'(in_center_y) + $signed(CW'(in_half_y));
    box_nxt.hi_z = CW'(in_center_z) + $signed(CW'(in_half_z));
  end

  // front stage
  assign f_en     = !f_v_r || chain_rdy[0];
  assign in_ready = f_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_en) begin
      f_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f_box_r <= box_nxt;
    end
  end

  assign chain_v[0]   = f_v_r;
  assign chain_box[0] = f_box_r;
  assign chain_ins[0] = 1'b1;

  // row of plane cells
  for (genvar i = 0; i < NP; i++) begin : g_cell
    bfct_cell #(
      .PLANE_IDX(bfct_pkg::bfct_reg_t'(i))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg_we    (cfg_we),
      .cfg_index (cfg_index),
      .cfg_wdata (cfg_wdata),
      .bias      (bias_r),
      .up_valid  (chain_v[i]),
      .up_ready  (chain_rdy[i]),
      .up_box    (chain_box[i]),
      .up_inside (chain_ins[i]),
      .dn_valid  (chain_v[i+1]),
      .dn_ready  (chain_rdy[i+1]),
      .dn_box    (chain_box[i+1]),
      .dn_inside (chain_ins[i+1])
    );
  end

  // result side
  assign chain_rdy[NP]  = out_ready;
  assign out_valid      = chain_v[NP];
  assign out_inside_res = chain_ins[NP];

endmodule

FILE: bench/tb_box_frustum_cull_test_unit.sv
// testbench for box_frustum_cull_test_unit: boxes are checked against six frustum planes
// a predictor in the bench computes each verdict, and a scoreboard compares it with the unit
// depends on bfct_pkg and the box_frustum_cull_test_unit rtl
module tb_box_frustum_cull_test_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W      = bfct_pkg::IDX_W;
  localparam int COEF_W     = bfct_pkg::COEF_W;
  localparam int DIST_W     = bfct_pkg::DIST_W;
  localparam int CTR_W      = bfct_pkg::CTR_W;
  localparam int HALF_W     = bfct_pkg::HALF_W;
  localparam int PLANE_W    = bfct_pkg::PLANE_W;
  localparam int BIAS_W     = bfct_pkg::BIAS_W;
  localparam int FRAC_ALN   = bfct_pkg::FRAC_ALN;
  localparam int NUM_PLANES = bfct_pkg::NUM_PLANES;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;  // no register behind this index
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam longint ALIGN = longint'(1) << FRAC_ALN;
  localparam longint COEF_HI = (longint'(1) << (COEF_W - 1)) - 1;
  localparam longint COEF_LO = -COEF_HI - 1;
  localparam longint DIST_HI = (longint'(1) << (DIST_W - 1)) - 1;
  localparam longint DIST_LO = -DIST_HI - 1;
  localparam logic signed [CTR_W-1:0] CTR_MAX = {1'b0, {(CTR_W - 1){1'b1}}};
  localparam logic signed [CTR_W-1:0] CTR_MIN = {1'b1, {(CTR_W - 1){1'b0}}};
  localparam logic [HALF_W-1:0] HALF_MAX = '1;

  typedef struct {
    logic signed [CTR_W-1:0] ctr [3];
    logic [HALF_W-1:0] half [3];
  } cull_box_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [PLANE_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic signed [CTR_W-1:0] in_center_x, in_center_y, in_center_z;
  logic [HALF_W-1:0] in_half_x, in_half_y, in_half_z;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res;

  // shadow of the unit's registers, and the next setting to load
  logic [PLANE_W-1:0] plane_cfg [NUM_PLANES] = '{default: '0};
  logic [BIAS_W-1:0] bias_cfg = '0;
  logic [PLANE_W-1:0] plane_next [NUM_PLANES];
  logic [PLANE_W-1:0] bias_next;

  bit expected_verdict_q [$];
  int error_count = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  box_frustum_cull_test_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_center_z    (in_center_z),
    .in_half_x      (in_half_x),
    .in_half_y      (in_half_y),
    .in_half_z      (in_half_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // box survives when every plane has some corner at or above the bias
  function automatic bit box_survives(input cull_box_t b);
    longint lo [3], hi [3];
    longint ca, cb, cc, d_al, bias_al, x, y, z;
    bit kept_all, keeps;
    int i, k;
    kept_all = 1'b1;
    bias_al = longint'($signed(bias_cfg)) * ALIGN;
    for (i = 0; i < 3; i++) begin
      lo[i] = longint'(b.ctr[i]) - longint'(b.half[i]);
      hi[i] = longint'(b.ctr[i]) + longint'(b.half[i]);
    end
    for (i = 0; i < NUM_PLANES; i++) begin
      ca = longint'($signed(plane_cfg[i][0 +: COEF_W]));
      cb = longint'($signed(plane_cfg[i][COEF_W +: COEF_W]));
      cc = longint'($signed(plane_cfg[i][2 * COEF_W +: COEF_W]));
      d_al = longint'($signed(plane_cfg[i][3 * COEF_W +: DIST_W])) * ALIGN;
      keeps = 1'b0;
      for (k = 0; k < 8; k++) begin
        x = (k & 1) ? hi[0] : lo[0];
        y = (k & 2) ? hi[1] : lo[1];
        z = (k & 4) ? hi[2] : lo[2];
        if (ca * x + cb * y + cc * z + d_al >= bias_al) keeps = 1'b1;
      end
      if (!keeps) kept_all = 1'b0;
    end
    return kept_all;
  endfunction

  function automatic logic [PLANE_W-1:0] pack_plane(input longint a, b, c, d);
    return {d[DIST_W-1:0], c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
  endfunction

  function automatic cull_box_t make_box(input longint cx, cy, cz, hx, hy, hz);
    cull_box_t b;
    b.ctr[0] = cx[CTR_W-1:0];
    b.ctr[1] = cy[CTR_W-1:0];
    b.ctr[2] = cz[CTR_W-1:0];
    b.half[0] = hx[HALF_W-1:0];
    b.half[1] = hy[HALF_W-1:0];
    b.half[2] = hz[HALF_W-1:0];
    return b;
  endfunction

  // mostly boxes near the frustum, some full-range and some at the field limits
  function automatic cull_box_t random_box();
    cull_box_t b;
    int j, mode;
    mode = $urandom_range(9);
    for (j = 0; j < 3; j++) begin
      case (mode)
        8, 9: begin
          b.ctr[j] = CTR_W'($urandom);
          b.half[j] = HALF_W'($urandom);
        end
        7: begin
          case ($urandom_range(2))
            0: b.ctr[j] = CTR_MIN;
            1: b.ctr[j] = CTR_MAX;
            default: b.ctr[j] = '0;
          endcase
          b.half[j] = $urandom_range(1) ? HALF_MAX : '0;
        end
        default: begin
          b.ctr[j] = CTR_W'(int'($urandom_range(10 << 17)) - (5 << 17));
          b.half[j] = ($urandom_range(7) == 0) ? '0 : HALF_W'($urandom_range(1 << 16));
        end
      endcase
    end
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // register write; cfg_we stays high so writes can go back to back
  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [PLANE_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx < bfct_pkg::REG_BIAS) plane_cfg[idx] = data;
    else if (idx == bfct_pkg::REG_BIAS) bias_cfg = data[BIAS_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply_config();
    int i;
    for (i = 0; i < NUM_PLANES; i++)
      write_reg(bfct_pkg::bfct_reg_t'(int'(bfct_pkg::REG_NEAR) + i), plane_next[i]);
    write_reg(bfct_pkg::REG_BIAS, bias_next);
    cfg_we <= 1'b0;
  endtask

  // one box request, with random idle cycles ahead of it
  task automatic send_box(input cull_box_t b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_center_x <= b.ctr[0];
    in_center_y <= b.ctr[1];
    in_center_z <= b.ctr[2];
    in_half_x <= b.half[0];
    in_half_y <= b.half[1];
    in_half_z <= b.half[2];
    do @(posedge clk); while (!in_ready);
  endtask

  // sender holds off until every outstanding verdict is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_verdict_q.size() != 0);
  endtask

  // random frustum: tilted axis slabs mostly, some raw, extreme or zero planes
  task automatic configure_random();
    int mode, i, j, axis;
    longint cf [3];
    longint mainc, bound;
    mode = $urandom_range(9);
    for (i = 0; i < NUM_PLANES; i++) begin
      if (mode < 7) begin
        axis = (i <= bfct_pkg::REG_FAR) ? 2 : (i <= bfct_pkg::REG_RIGHT) ? 0 : 1;
        for (j = 0; j < 3; j++) cf[j] = longint'(int'($urandom_range(512)) - 256);
        mainc = longint'($urandom_range(8191, 2048));
        bound = longint'($urandom_range(1 << 19));
        if (i == bfct_pkg::REG_FAR || i == bfct_pkg::REG_RIGHT || i == bfct_pkg::REG_TOP)
          mainc = -mainc;
        else bound = -bound;
        cf[axis] = mainc;
        plane_next[i] = pack_plane(cf[0], cf[1], cf[2], -((mainc * bound) >>> FRAC_ALN));
      end else if (mode == 7) begin
        plane_next[i] = {$urandom, $urandom};
      end else if (mode == 8) begin
        plane_next[i] = pack_plane($urandom_range(1) ? COEF_HI : COEF_LO,
                                   $urandom_range(1) ? COEF_HI : COEF_LO,
                                   $urandom_range(1) ? COEF_HI : COEF_LO,
                                   $urandom_range(1) ? DIST_HI : DIST_LO);
      end else begin
        plane_next[i] = '0;
      end
    end
    case (mode)
      7: bias_next = {$urandom, $urandom};
      8: bias_next = {$urandom, $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000};
      9: bias_next = {$urandom, 32'(int'($urandom_range(2)) - 1)};
      default: bias_next = {$urandom, ($urandom_range(3) == 0) ?
                            32'(int'($urandom_range(8192)) - 4096) : 32'h0};
    endcase
    apply_config();
  endtask

  // reset state: zero planes and zero bias keep every box
  task automatic test_reset_state();
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(CTR_MIN, CTR_MIN, CTR_MIN, HALF_MAX, HALF_MAX, HALF_MAX));
    send_box(make_box(CTR_MAX, CTR_MAX, CTR_MAX, HALF_MAX, 0, HALF_MAX));
  endtask

  // zero planes against a positive and a negative bias, upper data bits ignored,
  // and a write to the unused index
  task automatic test_bias_threshold();
    wait_drained();
    write_reg(bfct_pkg::REG_BIAS, {32'hffff_ffff, 32'h0000_0001});
    cfg_we <= 1'b0;
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(CTR_MAX, CTR_MIN, 0, HALF_MAX, HALF_MAX, HALF_MAX));
    wait_drained();
    write_reg(bfct_pkg::REG_BIAS, {32'h0, 32'h8000_0000});
    cfg_we <= 1'b0;
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(CTR_MIN, CTR_MAX, CTR_MIN, 0, 0, 0));
    wait_drained();
    write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_box(make_box(-1, -1, -1, 1, 1, 1));
    send_box(make_box(CTR_MAX, CTR_MAX, CTR_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
  endtask

  // largest coefficients and offsets, with the bias at both ends
  task automatic test_coef_extremes();
    wait_drained();
    plane_next[bfct_pkg::REG_NEAR] = pack_plane(COEF_LO, COEF_HI, COEF_LO, DIST_HI);
    plane_next[bfct_pkg::REG_FAR] = pack_plane(COEF_HI, COEF_LO, COEF_HI, DIST_LO);
    plane_next[bfct_pkg::REG_LEFT] = pack_plane(COEF_HI, COEF_HI, COEF_HI, DIST_HI);
    plane_next[bfct_pkg::REG_RIGHT] = pack_plane(COEF_LO, COEF_LO, COEF_LO, DIST_LO);
    plane_next[bfct_pkg::REG_TOP] = pack_plane(COEF_HI, 0, COEF_LO, 0);
    plane_next[bfct_pkg::REG_BOTTOM] = pack_plane(0, COEF_LO, COEF_HI, DIST_HI);
    bias_next = {32'h0, 32'h8000_0000};
    apply_config();
    send_box(make_box(CTR_MAX, CTR_MAX, CTR_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
    send_box(make_box(CTR_MIN, CTR_MIN, CTR_MIN, HALF_MAX, HALF_MAX, HALF_MAX));
    send_box(make_box(CTR_MIN, CTR_MAX, CTR_MIN, 0, 0, 0));
    wait_drained();
    bias_next = {32'hffff_ffff, 32'h7fff_ffff};
    apply_config();
    send_box(make_box(CTR_MAX, CTR_MIN, CTR_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
    send_box(make_box(CTR_MIN, CTR_MIN, CTR_MAX, HALF_MAX, 0, HALF_MAX));
    send_box(make_box(0, 0, 0, 0, 0, 0));
  endtask

  // unit-normal slab frustum, faces at +-25600: inside, past each face,
  // exactly touching a face, straddling a face and enclosing the frustum
  task automatic test_slab_frustum();
    wait_drained();
    plane_next[bfct_pkg::REG_NEAR] = pack_plane(0, 0, 4096, 25600);
    plane_next[bfct_pkg::REG_FAR] = pack_plane(0, 0, -4096, 25600);
    plane_next[bfct_pkg::REG_LEFT] = pack_plane(4096, 0, 0, 25600);
    plane_next[bfct_pkg::REG_RIGHT] = pack_plane(-4096, 0, 0, 25600);
    plane_next[bfct_pkg::REG_TOP] = pack_plane(0, -4096, 0, 25600);
    plane_next[bfct_pkg::REG_BOTTOM] = pack_plane(0, 4096, 0, 25600);
    bias_next = '0;
    apply_config();
    send_box(make_box(0, 0, 0, 256, 256, 256));
    send_box(make_box(0, 0, -26600, 500, 500, 500));
    send_box(make_box(0, 0, 26600, 500, 500, 500));
    send_box(make_box(-26600, 0, 0, 500, 500, 500));
    send_box(make_box(26600, 0, 0, 500, 500, 500));
    send_box(make_box(0, 26600, 0, 500, 500, 500));
    send_box(make_box(0, -26600, 0, 500, 500, 500));
    send_box(make_box(0, 0, -26100, 500, 500, 500));
    send_box(make_box(25600, 0, 0, 1000, 1000, 1000));
    send_box(make_box(0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX));
  endtask

  // random boxes in groups, each group under a fresh frustum
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_boxes);
    int sent, group, k;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    sent = 0;
    while (sent < n_boxes) begin
      wait_drained();
      configure_random();
      group = $urandom_range(70, 30);
      for (k = 0; k < group && sent < n_boxes; k++) begin
        send_box(random_box());
        sent++;
      end
    end
  endtask

  // predict on each accepted box, compare each accepted verdict
  always @(posedge clk) begin : scoreboard
    cull_box_t seen;
    bit want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen = make_box(in_center_x, in_center_y, in_center_z, in_half_x, in_half_y, in_half_z);
        expected_verdict_q.push_back(box_survives(seen));
      end
      if (out_valid && out_ready) begin
        if (expected_verdict_q.size() == 0) begin
          report_mismatch("verdict with no box outstanding");
        end else begin
          want = expected_verdict_q.pop_front();
          if (out_inside_res !== want)
            report_mismatch($sformatf("inside_res got %b expected %b", out_inside_res, want));
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or accepted verdict
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // test sequence
  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= bfct_pkg::REG_NEAR;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_center_x <= '0;
    in_center_y <= '0;
    in_center_z <= '0;
    in_half_x <= '0;
    in_half_y <= '0;
    in_half_z <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_bias_threshold();
    test_coef_extremes();
    test_slab_frustum();
    test_random_traffic(17, 73, 250);
    test_random_traffic(73, 17, 250);
    test_random_traffic(0, 0, 250);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: box_frustum_cull_test_unit.f
+incdir+rtl/core
rtl/core/bfct_pkg.sv
rtl/core/bfct_cell.sv
rtl/core/box_frustum_cull_test_unit.sv
bench/tb_box_frustum_cull_test_unit.sv
